// File: rtl/core/icc_pkg.sv
// Shared types, widths and codes of the image kernel correlation core.
// Depends on nothing; the tap sequencer, the datapath and the top file import it.
package icc_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned RowW      = 6;
  localparam int unsigned ColW      = 6;
  localparam int unsigned TapIdxW   = 4;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned ResultW   = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned FracW     = 4;

  // Default structural sizes.
  localparam int unsigned MaxSideDef    = 64;
  localparam int unsigned KernelSideDef = 3;

  // Configuration values after reset.
  localparam logic [SizeW-1:0] WidthRst  = SizeW'(64);
  localparam logic [SizeW-1:0] HeightRst = SizeW'(64);
  localparam logic [FracW-1:0] FracRst   = FracW'(12);

  // Input word actions.
  typedef enum logic [ActionW-1:0] {
    ACT_COEF    = 2'd0,
    ACT_PIXEL   = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FRAC   = 2'd2
  } cfg_idx_e;

  // Control that travels with each tap read through the datapath.
  typedef struct packed {
    logic issue;  // a tap read was issued this cycle
    logic hit;    // the tap lies inside the image
    logic last;   // final tap of the kernel
  } tap_ctl_t;

endpackage

// File: rtl/core/icc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the pixel and coefficient stores.
module icc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/icc_tap_seq.sv
// Tap sequencer: walks the kernel taps one per cycle and issues store reads.
// Depends on icc_pkg.
module icc_tap_seq #(
  parameter int unsigned MaxSide    = icc_pkg::MaxSideDef,
  parameter int unsigned KernelSide = icc_pkg::KernelSideDef,
  parameter int unsigned PixAddrW   = $clog2(MaxSide * MaxSide),
  parameter int unsigned TapW       = (KernelSide * KernelSide > 1) ?
                                      $clog2(KernelSide * KernelSide) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [icc_pkg::RowW-1:0]  row_i,
  input  logic [icc_pkg::ColW-1:0]  col_i,
  input  logic [icc_pkg::SizeW-1:0] width_i,
  input  logic [icc_pkg::SizeW-1:0] height_i,
  output logic                      busy_o,
  output logic                      rd_en_o,
  output logic [PixAddrW-1:0]       pix_raddr_o,
  output logic [TapW-1:0]           coef_raddr_o,
  output icc_pkg::tap_ctl_t         ctl_o
);
  import icc_pkg::*;

  localparam int unsigned Taps  = KernelSide * KernelSide;
  localparam int unsigned KW    = (KernelSide > 1) ? $clog2(KernelSide) : 1;
  localparam int unsigned Half  = KernelSide / 2;
  localparam int unsigned SideW = $clog2(MaxSide);
  localparam int unsigned CrdW  = (SideW + 2 > 9) ? SideW + 2 : 9;
  localparam logic signed [CrdW-1:0] SideC = CrdW'(MaxSide);

  logic            busy_q, busy_d;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [KW-1:0]   kr_q, kr_d;
  logic [KW-1:0]   kc_q, kc_d;
  logic [TapW-1:0] tap_q, tap_d;
  logic            last_tap;
  logic signed [CrdW-1:0] r_s, c_s;
  logic            hit;

  // Neighbor coordinates of the current tap.
  assign r_s = $signed(CrdW'(row_q) + CrdW'(kr_q) - CrdW'(Half));
  assign c_s = $signed(CrdW'(col_q) + CrdW'(kc_q) - CrdW'(Half));

  // A tap counts only inside the configured image, which is clamped to the store.
  assign hit = !r_s[CrdW-1] && !c_s[CrdW-1] &&
               (r_s < $signed(CrdW'(height_i))) && (r_s < SideC) &&
               (c_s < $signed(CrdW'(width_i)))  && (c_s < SideC);

  assign last_tap = (32'(tap_q) == Taps - 1);

  // Counter advance.
  always_comb begin
    busy_d = busy_q;
    kr_d   = kr_q;
    kc_d   = kc_q;
    tap_d  = tap_q;
    if (start_i) begin
      busy_d = 1'b1;
      kr_d   = '0;
      kc_d   = '0;
      tap_d  = '0;
    end else if (busy_q) begin
      tap_d = tap_q + TapW'(1);
      if (32'(kc_q) == KernelSide - 1) begin
        kc_d = '0;
        kr_d = kr_q + KW'(1);
      end else begin
        kc_d = kc_q + KW'(1);
      end
      if (last_tap) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kr_q   <= '0;
      kc_q   <= '0;
      tap_q  <= '0;
    end else begin
      busy_q <= busy_d;
      kr_q   <= kr_d;
      kc_q   <= kc_d;
      tap_q  <= tap_d;
    end
  end

  // The request position is held for the whole kernel walk.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  // Store reads; an outside tap reads entry zero and is masked later.
  assign busy_o       = busy_q;
  assign rd_en_o      = busy_q;
  assign coef_raddr_o = tap_q;
  assign pix_raddr_o  = hit ? (PixAddrW'(r_s) * PixAddrW'(MaxSide) + PixAddrW'(c_s))
                            : '0;
  assign ctl_o.issue  = busy_q;
  assign ctl_o.hit    = hit;
  assign ctl_o.last   = last_tap;

endmodule

// File: rtl/core/icc_mac.sv
// Multiply-accumulate datapath with the final shift and saturation.
// Depends on icc_pkg; fed by the store read data and the tap sequencer.
module icc_mac #(
  parameter int unsigned KernelSide = icc_pkg::KernelSideDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [icc_pkg::FracW-1:0]     frac_i,
  input  icc_pkg::tap_ctl_t             ctl_i,
  input  logic signed [icc_pkg::ValueW-1:0] pix_i,
  input  logic signed [icc_pkg::ValueW-1:0] coef_i,
  output logic                          fin_o,
  output logic signed [icc_pkg::ResultW-1:0] result_o,
  output logic                          saturated_o
);
  import icc_pkg::*;

  localparam int unsigned Taps  = KernelSide * KernelSide;
  localparam int unsigned ProdW = 2 * ValueW;
  localparam int unsigned AccW  = ProdW + ((Taps > 1) ? $clog2(Taps) : 0) + 1;

  tap_ctl_t s1_q, s2_q;
  logic     fin1_q, fin2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  biased;
  logic signed [AccW-1:0]  shft_q;
  logic [AccW-1:0]         bias;
  logic                    fits;

  // Control pipeline: read data arrives with s1, the product with s2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      fin1_q <= 1'b0;
      fin2_q <= 1'b0;
    end else begin
      s1_q   <= ctl_i;
      s2_q   <= s1_q;
      fin1_q <= s2_q.issue && s2_q.last;
      fin2_q <= fin1_q;
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    prod_q <= pix_i * coef_i;
  end

  // Accumulator, cleared when a request starts.
  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (s2_q.issue && s2_q.hit) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Shift toward zero: a negative sum is biased by 2^frac - 1 first.
  assign bias   = acc_q[AccW-1] ? AccW'((17'd1 << frac_i) - 17'd1) : '0;
  assign biased = acc_q + $signed(bias);

  always_ff @(posedge clk_i) begin
    if (fin1_q) begin
      shft_q <= biased >>> frac_i;
    end
  end

  // Saturation to the 32-bit range.
  assign fits = (shft_q[AccW-1:ResultW-1] == '0) || (shft_q[AccW-1:ResultW-1] == '1);

  always_comb begin
    if (fits) begin
      result_o = shft_q[ResultW-1:0];
    end else if (shft_q[AccW-1]) begin
      result_o = {1'b1, {(ResultW-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(ResultW-1){1'b1}}};
    end
  end

  assign saturated_o = !fits;
  assign fin_o       = fin2_q;

endmodule

// File: rtl/core/image_kernel_correlation_core.sv
// Image kernel correlation core: 2D correlation of a stored frame with a K by K centered kernel.
//
// Input channel (in_valid_i / in_stall_o) carries one word per action:
// a coefficient write, a pixel write, or a compute request at row and col.
// A word is taken at a rising edge with valid high and stall low. Writes
// return nothing. A compute request walks the K*K taps through the tap
// sequencer, one pixel and one coefficient read per cycle, then passes a
// multiply stage, the accumulator, a shift stage and the output register.
// The input stalls until the result word is loaded into the output
// register, so the next word is taken only then. The K*K reads go through
// the one read port of each store.
//
// Output channel (out_valid_o / out_stall_i) carries result and saturated.
// The output register holds a word while the receiver stalls; writes are
// still taken meanwhile, and a finished compute waits until the register
// is free.
//
// Reset clears the control state and sets width and height to 64 and the
// fraction bits to 12. The stores are not cleared. The user must write the
// configuration port only while the core is idle; the core does not enforce it.
module image_kernel_correlation_core #(
  parameter int unsigned MaxSide    = icc_pkg::MaxSideDef,
  parameter int unsigned KernelSide = icc_pkg::KernelSideDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [icc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [icc_pkg::CfgDataW-1:0]       cfg_data_i,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [icc_pkg::ActionW-1:0]        action_i,
  input  logic [icc_pkg::RowW-1:0]           row_i,
  input  logic [icc_pkg::ColW-1:0]           col_i,
  input  logic [icc_pkg::TapIdxW-1:0]        tap_index_i,
  input  logic signed [icc_pkg::ValueW-1:0]  value_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [icc_pkg::ResultW-1:0] result_o,
  output logic                               saturated_o
);
  import icc_pkg::*;

  localparam int unsigned Taps     = KernelSide * KernelSide;
  localparam int unsigned TapW     = (Taps > 1) ? $clog2(Taps) : 1;
  localparam int unsigned PixDepth = MaxSide * MaxSide;
  localparam int unsigned PixAddrW = $clog2(PixDepth);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [SizeW-1:0] width_q, height_q;
  logic [FracW-1:0] frac_q;

  logic in_acc;
  logic start;
  logic pix_we, coef_we;
  logic [PixAddrW-1:0] pix_waddr;
  logic [TapW-1:0]     coef_waddr;

  logic                seq_busy;
  logic                rd_en;
  logic [PixAddrW-1:0] pix_raddr;
  logic [TapW-1:0]     coef_raddr;
  tap_ctl_t            tap_ctl;
  logic [ValueW-1:0]   pix_rdata, coef_rdata;

  logic                      mac_fin;
  logic signed [ResultW-1:0] mac_result;
  logic                      mac_sat;

  logic                      out_valid_q, out_valid_d;
  logic signed [ResultW-1:0] result_q;
  logic                      sat_q;
  logic                      out_free;
  logic                      out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      frac_q   <= FracRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
        CFG_FRAC:   frac_q   <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  // Input word decode.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    start   = 1'b0;
    pix_we  = 1'b0;
    coef_we = 1'b0;
    if (in_acc) begin
      unique case (action_e'(action_i))
        ACT_COEF:    coef_we = (32'(tap_index_i) < Taps);
        ACT_PIXEL:   pix_we  = (32'(row_i) < MaxSide) && (32'(col_i) < MaxSide);
        ACT_COMPUTE: start   = 1'b1;
        default: ;
      endcase
    end
  end

  assign pix_waddr  = PixAddrW'(row_i) * PixAddrW'(MaxSide) + PixAddrW'(col_i);
  assign coef_waddr = TapW'(tap_index_i);

  // Sequencer state.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start)    state_d = ST_RUN;
      ST_RUN:  if (mac_fin)  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Kernel walk.
  icc_tap_seq #(
    .MaxSide    (MaxSide),
    .KernelSide (KernelSide),
    .PixAddrW   (PixAddrW),
    .TapW       (TapW)
  ) u_tap_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .row_i        (row_i),
    .col_i        (col_i),
    .width_i      (width_q),
    .height_i     (height_q),
    .busy_o       (seq_busy),
    .rd_en_o      (rd_en),
    .pix_raddr_o  (pix_raddr),
    .coef_raddr_o (coef_raddr),
    .ctl_o        (tap_ctl)
  );

  // Frame store.
  icc_ram #(
    .Width (ValueW),
    .Depth (PixDepth),
    .AddrW (PixAddrW)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  // Coefficient store.
  icc_ram #(
    .Width (ValueW),
    .Depth (Taps),
    .AddrW (TapW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Multiply, accumulate, shift and saturate.
  icc_mac #(
    .KernelSide (KernelSide)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start),
    .frac_i      (frac_q),
    .ctl_i       (tap_ctl),
    .pix_i       ($signed(pix_rdata)),
    .coef_i      ($signed(coef_rdata)),
    .fin_o       (mac_fin),
    .result_o    (mac_result),
    .saturated_o (mac_sat)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= mac_result;
      sat_q    <= mac_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign saturated_o = sat_q;

  // A compute request holds off the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_COMPUTE) |=> in_stall_o)
    else $error("compute request did not stall the input");

  // The kernel walk runs only while a request is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_busy || mac_fin) |-> (state_q == ST_RUN))
    else $error("tap walk or finish outside the run state");

  // A new result word comes only from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result word without a finished request");

endmodule
